// File: rtl/i2r_pkg.sv
`timescale 1ns / 1ps
// Package: item types, letter codes and the microcode ROM of the Roman numeral encoder.
package i2r_pkg;

	localparam int unsigned ValueWidth = 12;
	localparam int unsigned StepWidth  = 4;
	localparam int unsigned ValWidth   = 11;

	localparam logic [ValueWidth-1:0] ValueMax = 12'd3999;
	localparam logic [StepWidth-1:0]  LastStep = 4'd12;

	localparam logic [7:0] NoLetter = 8'h00;
	localparam logic [7:0] LetterI  = 8'h49;
	localparam logic [7:0] LetterV  = 8'h56;
	localparam logic [7:0] LetterX  = 8'h58;
	localparam logic [7:0] LetterL  = 8'h4C;
	localparam logic [7:0] LetterC  = 8'h43;
	localparam logic [7:0] LetterD  = 8'h44;
	localparam logic [7:0] LetterM  = 8'h4D;

	typedef struct packed {
		logic [ValueWidth-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
		logic       bad_input;
	} out_item_t;

	// One control word per step: value to compare and subtract, the letters it
	// emits, and the step to jump to once it has been emitted.
	typedef struct packed {
		logic [ValWidth-1:0]  val;
		logic [7:0]           first;
		logic [7:0]           second;
		logic [StepWidth-1:0] jump;
	} ucode_t;

	function automatic ucode_t ucode(input logic [StepWidth-1:0] step);
		ucode_t w;
		unique case (step)
			4'd0:    w = '{11'd1000, LetterM, NoLetter, 4'd0};
			4'd1:    w = '{11'd900,  LetterC, LetterM,  4'd5};
			4'd2:    w = '{11'd500,  LetterD, NoLetter, 4'd4};
			4'd3:    w = '{11'd400,  LetterC, LetterD,  4'd5};
			4'd4:    w = '{11'd100,  LetterC, NoLetter, 4'd4};
			4'd5:    w = '{11'd90,   LetterX, LetterC,  4'd9};
			4'd6:    w = '{11'd50,   LetterL, NoLetter, 4'd8};
			4'd7:    w = '{11'd40,   LetterX, LetterL,  4'd9};
			4'd8:    w = '{11'd10,   LetterX, NoLetter, 4'd8};
			4'd9:    w = '{11'd9,    LetterI, LetterX,  LastStep};
			4'd10:   w = '{11'd5,    LetterV, NoLetter, LastStep};
			4'd11:   w = '{11'd4,    LetterI, LetterV,  LastStep};
			default: w = '{11'd1,    LetterI, NoLetter, LastStep};
		endcase
		return w;
	endfunction

endpackage

// File: rtl/i2r_if.sv
`timescale 1ns / 1ps
// Interface: valid/ready channel carrying one item of a given payload type.
interface i2r_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/i2r_seq.sv
`timescale 1ns / 1ps
// Module: microcoded sequencer and datapath that turn one value into numeral letters.
module i2r_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  i2r_pkg::in_item_t             in_item,
	output logic                          in_ready,
	output logic                          emit_valid,
	output i2r_pkg::out_item_t            emit_item,
	input  logic                          emit_take
);
	import i2r_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		RUN,
		PAIR,
		ERR
	} state_t;

	state_t                state_q;
	logic [StepWidth-1:0]  pc_q;
	logic [ValueWidth-1:0] rem_q;

	ucode_t                word;
	logic [ValueWidth-1:0] val_ext;
	logic                  ge;
	logic [ValueWidth-1:0] diff;
	logic                  in_bad;

	assign word    = ucode(pc_q);
	assign val_ext = {{(ValueWidth-ValWidth){1'b0}}, word.val};
	assign ge      = rem_q >= val_ext;
	assign diff    = rem_q - val_ext;
	assign in_bad  = (in_item.value == '0) || (in_item.value > ValueMax);
	assign in_ready = (state_q == IDLE);

	always_comb begin
		emit_valid          = 1'b0;
		emit_item.symbol    = NoLetter;
		emit_item.last      = 1'b0;
		emit_item.bad_input = 1'b0;
		unique case (state_q)
			IDLE: begin
				emit_valid = 1'b0;
			end
			RUN: begin
				emit_valid       = ge;
				emit_item.symbol = word.first;
				emit_item.last   = (word.second == NoLetter) && (diff == '0);
			end
			PAIR: begin
				emit_valid       = 1'b1;
				emit_item.symbol = word.second;
				emit_item.last   = (diff == '0);
			end
			ERR: begin
				emit_valid          = 1'b1;
				emit_item.last      = 1'b1;
				emit_item.bad_input = 1'b1;
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			pc_q    <= '0;
			rem_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						pc_q <= '0;
						if (in_bad) begin
							state_q <= ERR;
						end else begin
							rem_q   <= in_item.value;
							state_q <= RUN;
						end
					end
				end
				RUN: begin
					if (!ge) begin
						pc_q <= pc_q + 1'b1;
					end else if (emit_take) begin
						if (word.second != NoLetter) begin
							state_q <= PAIR;
						end else begin
							rem_q <= diff;
							pc_q  <= word.jump;
							if (diff == '0) begin
								state_q <= IDLE;
							end
						end
					end
				end
				PAIR: begin
					if (emit_take) begin
						rem_q   <= diff;
						pc_q    <= word.jump;
						state_q <= (diff == '0) ? IDLE : RUN;
					end
				end
				ERR: begin
					if (emit_take) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	// The step counter never runs past the final step while letters remain.
	a_pc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN) |-> (pc_q <= LastStep))
		else $error("step counter ran past the last step");

	// A numeral in progress always has something left to encode.
	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == RUN) || (state_q == PAIR)) |-> (rem_q != '0))
		else $error("sequencer running with nothing remaining");

	// An error item is a single, final item.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_valid && emit_item.bad_input) |-> (emit_item.last && emit_item.symbol == NoLetter))
		else $error("error item not marked last");

	// A pair's first letter, emitted from RUN, never closes the numeral early.
	a_pair_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == RUN && emit_valid && word.second != NoLetter) |-> !emit_item.last)
		else $error("first letter of a pair marked last");
endmodule

// File: rtl/integer_to_roman_encoder_top.sv
`timescale 1ns / 1ps
// Top level: integer to Roman numeral encoder with registered output channel.
// The first letter is loaded into the output register after the input item is taken and
//   the step counter has passed each failed compare before it (at most 12, for input 1).
// Each item is loaded, then emits its letters (at most 15) one by one as the output register
//   takes them, stepping past each failed compare (at most 12); an error emits one item.
// The sequencer handles one item at a time; the output register decouples the sink.
// Reset (arst_n low, asynchronous): sequencer idle, output register empty.
module integer_to_roman_encoder_top (
	input  logic clk,
	input  logic arst_n,
	i2r_if.sink   in_ch,
	i2r_if.source out_ch
);
	import i2r_pkg::*;

	logic      emit_valid;
	out_item_t emit_item;
	logic      emit_take;
	logic      seq_ready;

	logic      out_valid_q;
	out_item_t out_q;

	// The output register can take a new letter when empty or being drained.
	assign emit_take = !out_valid_q || out_ch.ready;

	i2r_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_item    (in_ch.data),
		.in_ready   (seq_ready),
		.emit_valid (emit_valid),
		.emit_item  (emit_item),
		.emit_take  (emit_take)
	);

	assign in_ch.ready = seq_ready;

	// Hold the letter until the sink takes it; advance only when the slot frees up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_take) begin
			out_valid_q <= emit_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_take && emit_valid) begin
			out_q <= emit_item;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = out_q;
endmodule

// File: verif/integer_to_roman_encoder_top_tb.sv
`timescale 1ns / 1ps
// Testbench: drives integers into the Roman numeral encoder and checks every emitted letter.
module integer_to_roman_encoder_top_tb;
	import i2r_pkg::*;

	// Letter-level scoreboard: expands each accepted integer into its numeral and
	// matches emitted letters against it in order.
	class roman_scoreboard;
		out_item_t letters_due[$];
		int unsigned numerals_seen;
		int unsigned bad_values_seen;
		int unsigned letters_checked;
		int unsigned fail_count;

		int unsigned step_val[13] = '{1000, 900, 500, 400, 100, 90, 50, 40, 10, 9, 5, 4, 1};
		logic [7:0] first_letter[13] = '{LetterM, LetterC, LetterD, LetterC, LetterC,
			LetterX, LetterL, LetterX, LetterX, LetterI, LetterV, LetterI, LetterI};
		logic [7:0] second_letter[13] = '{NoLetter, LetterM, NoLetter, LetterD, NoLetter,
			LetterC, NoLetter, LetterL, NoLetter, LetterX, NoLetter, LetterV, NoLetter};

		// Append one letter of a numeral; last is patched once the numeral is done.
		function void push_letter(input logic [7:0] letter);
			out_item_t item;
			item.symbol    = letter;
			item.last      = 1'b0;
			item.bad_input = 1'b0;
			letters_due.push_back(item);
		endfunction

		// Expand an accepted integer into the letters the encoder must emit.
		function void note_value(input logic [ValueWidth-1:0] value);
			out_item_t err_item;
			int unsigned left;
			numerals_seen++;
			if (value == '0 || value > ValueMax) begin
				bad_values_seen++;
				err_item.symbol    = NoLetter;
				err_item.last      = 1'b1;
				err_item.bad_input = 1'b1;
				letters_due.push_back(err_item);
			end else begin
				left = 32'(value);
				for (int i = 0; i < 13; i++) begin
					while (left >= step_val[i]) begin
						push_letter(first_letter[i]);
						if (second_letter[i] != NoLetter)
							push_letter(second_letter[i]);
						left -= step_val[i];
					end
				end
				letters_due[letters_due.size()-1].last = 1'b1;
			end
		endfunction

		// Compare one emitted letter with the oldest letter still due.
		function void check_letter(input out_item_t got);
			out_item_t want;
			letters_checked++;
			if (letters_due.size() == 0) begin
				$error("letter with no numeral pending: symbol %h last %b bad_input %b",
					got.symbol, got.last, got.bad_input);
				fail_count++;
				return;
			end
			want = letters_due.pop_front();
			if (got.symbol !== want.symbol) begin
				$error("symbol mismatch: expected %h, got %h", want.symbol, got.symbol);
				fail_count++;
			end
			if (got.last !== want.last) begin
				$error("last mismatch: expected %b, got %b", want.last, got.last);
				fail_count++;
			end
			if (got.bad_input !== want.bad_input) begin
				$error("bad_input mismatch: expected %b, got %b", want.bad_input,
					got.bad_input);
				fail_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	i2r_if #(.T(in_item_t))  in_bus ();
	i2r_if #(.T(out_item_t)) out_bus ();

	integer_to_roman_encoder_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_bus),
		.out_ch (out_bus)
	);

	roman_scoreboard sb = new();

	// Percent of cycles in which each side holds off.
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;

	logic [ValueWidth-1:0] directed_values[$] = '{
		12'd1, 12'd3999, 12'd0, 12'd4000, 12'd4095, 12'd3888,
		12'd4, 12'd9, 12'd40, 12'd90, 12'd400, 12'd900,
		12'd1000, 12'd500, 12'd100, 12'd50, 12'd10, 12'd5,
		12'd1994, 12'd2730, 12'd1365, 12'd2048
	};
	logic [ValueWidth-1:0] next_value;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Receiver: decide ready afresh every cycle from the current stall rate.
	always @(posedge clk) begin
		out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Sample both channels at the falling edge: whatever is valid and
	// ready here is taken at the next rising edge, and nothing moves in between.
	always @(negedge clk) begin
		if (arst_n === 1'b1) begin
			if (in_bus.valid && in_bus.ready)
				sb.note_value(in_bus.data.value);
			if (out_bus.valid && out_bus.ready)
				sb.check_letter(out_bus.data);
		end
	end

	// Offer one integer, idling first at the current rate, and hold it until taken.
	// Return at the rising edge that accepted it.
	task automatic send_value(input logic [ValueWidth-1:0] value);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_bus.valid <= 1'b0;
			@(posedge clk);
		end
		in_bus.valid      <= 1'b1;
		in_bus.data.value <= value;
		do begin
			@(negedge clk);
			taken = in_bus.ready;
			@(posedge clk);
		end while (!taken);
	endtask

	// Most random integers are in range, with a share of short numerals; the rest
	// are zero or above the top of the range.
	function automatic logic [ValueWidth-1:0] pick_value();
		int unsigned kind;
		kind = $urandom_range(99);
		if (kind < 6)
			return '0;
		else if (kind < 14)
			return ValueWidth'($urandom_range(4095, 4000));
		else if (kind < 30)
			return ValueWidth'($urandom_range(20, 1));
		else
			return ValueWidth'($urandom_range(3999, 1));
	endfunction

	initial begin
		arst_n         <= 1'b0;
		in_bus.valid   <= 1'b0;
		in_bus.data    <= '0;
		send_idle_pct  = 26;
		recv_idle_pct  = 62;

		// Hold reset, then release it on a rising edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed integers: range ends, every table entry and both error cases.
		foreach (directed_values[i])
			send_value(directed_values[i]);

		// Random integers in three stretches: slow receiver, then slow sender,
		// then full rate on both sides.
		for (int n = 0; n < 100; n++) begin
			if (n == 33) begin
				send_idle_pct = 62;
				recv_idle_pct = 26;
			end else if (n == 66) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			next_value = pick_value();
			send_value(next_value);
		end
		in_bus.valid <= 1'b0;

		// Drain every pending letter, then watch a while longer for strays.
		while (sb.letters_due.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (sb.letters_due.size() != 0) begin
			$error("%0d letters never emitted", sb.letters_due.size());
			sb.fail_count++;
		end

		$display("Covered %0d integers (%0d out of range) and checked %0d letters,",
			sb.numerals_seen, sb.bad_values_seen, sb.letters_checked);
		$display("under sender stalls, receiver stalls and full-rate traffic.");
		if (sb.fail_count == 0) begin
			$display("PASS integer_to_roman_encoder_top");
		end else begin
			$display("FAIL integer_to_roman_encoder_top");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#400000;
		$display("FAIL integer_to_roman_encoder_top");
		$finish;
	end

endmodule

// File: integer_to_roman_encoder_top.f
rtl/i2r_pkg.sv
rtl/i2r_if.sv
rtl/i2r_seq.sv
rtl/integer_to_roman_encoder_top.sv
verif/integer_to_roman_encoder_top_tb.sv
